@@ rtl/itoa_pkg.sv @@
// Shared types, codes and character helpers for the integer-to-ASCII formatter.
package itoa_pkg;

  localparam int BinW   = 32;
  localparam int DigMax = 10;            // decimal digits of 2**32-1
  localparam int BcdW   = 4 * DigMax;
  localparam int HexDig = BinW / 4;

  localparam logic [1:0] TYPE_UDEC = 2'd0;
  localparam logic [1:0] TYPE_SDEC = 2'd1;
  localparam logic [1:0] TYPE_HEX  = 2'd2;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_X     = 7'h78;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_F     = 7'h66;
  localparam logic [6:0] CHAR_NINE  = 7'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // one nibble to lower-case ASCII
  function automatic logic [6:0] nib_to_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

  // double-dabble correction: add 3 to every BCD digit of 5 or more
  function automatic logic [BcdW-1:0] bcd_adjust(input logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    for (int i = 0; i < DigMax; i++) begin
      r[4*i +: 4] = (b[4*i +: 4] >= 4'd5) ? b[4*i +: 4] + 4'd3 : b[4*i +: 4];
    end
    return r;
  endfunction

endpackage

@@ rtl/integer_to_ascii_formatter.sv @@
// Integer-to-ASCII formatter: 32-bit word to decimal or hex text, one char per beat.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  request  | start / busy       | req_type[1:0], value[31:0]
//  result   | char_valid strobe  | character[6:0], last_char
//
// Decimal: shift-and-add-3 over all 32 input bits in one shared BCD unit,
// then a '-' sign for a negative signed value, then leading zeros are
// dropped one at a time (the final digit is always kept), then the digits
// are emitted. Hex: two prefix chars, then eight digits. Results are
// registered and come the cycle after the sequencer emits them.
// rst is synchronous; busy stays high from the accepting edge until the
// cycle the last character appears. The receiver cannot stall.
module integer_to_ascii_formatter import itoa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [BinW-1:0]  value,
  output logic             char_valid,
  output logic [6:0]       character,
  output logic             last_char
);

  state_t          state, state_next;
  logic [BinW-1:0] bin, bin_next;
  logic [BcdW-1:0] bcd, bcd_next;
  logic [4:0]      cnt, cnt_next;
  logic [3:0]      ndig, ndig_next;
  logic            neg, neg_next;

  logic            emit;
  logic [6:0]      emit_char;
  logic            emit_last;
  logic [BcdW-1:0] bcd_adj;

  assign bcd_adj = bcd_adjust(bcd);
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state      <= state_next;
      char_valid <= emit;
    end
    bin       <= bin_next;
    bcd       <= bcd_next;
    cnt       <= cnt_next;
    ndig      <= ndig_next;
    neg       <= neg_next;
    character <= emit_char;
    last_char <= emit_last;
  end

  always_comb begin
    state_next = state;
    bin_next   = bin;
    bcd_next   = bcd;
    cnt_next   = cnt;
    ndig_next  = ndig;
    neg_next   = neg;
    emit       = 1'b0;
    emit_char  = nib_to_char(bcd[BcdW-1 -: 4]);
    emit_last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cnt_next = '0;
          if (req_type == TYPE_HEX) begin
            bcd_next   = {value, {(BcdW-BinW){1'b0}}};
            ndig_next  = 4'(HexDig);
            state_next = ST_PFX0;
          end else begin
            neg_next   = (req_type == TYPE_SDEC) && value[BinW-1];
            bin_next   = ((req_type == TYPE_SDEC) && value[BinW-1]) ? (~value + 1'b1) : value;
            bcd_next   = '0;
            ndig_next  = 4'(DigMax);
            state_next = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_next = {bcd_adj[BcdW-2:0], bin[BinW-1]};
        bin_next = {bin[BinW-2:0], 1'b0};
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(BinW-1)) begin
          state_next = neg ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        emit       = 1'b1;
        emit_char  = CHAR_MINUS;
        state_next = ST_SKIP;
      end
      ST_PFX0: begin
        emit       = 1'b1;
        emit_char  = CHAR_ZERO;
        state_next = ST_PFXX;
      end
      ST_PFXX: begin
        emit       = 1'b1;
        emit_char  = CHAR_X;
        state_next = ST_EMIT;
      end
      ST_SKIP: begin
        // drop leading zeros, always keep the final digit
        if (bcd[BcdW-1 -: 4] == 4'd0 && ndig != 4'd1) begin
          bcd_next  = {bcd[BcdW-5:0], 4'd0};
          ndig_next = ndig - 4'd1;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit      = 1'b1;
        emit_last = (ndig == 4'd1);
        bcd_next  = {bcd[BcdW-5:0], 4'd0};
        ndig_next = ndig - 4'd1;
        if (ndig == 4'd1) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // busy is already low in the cycle the final character is shown, and drops only then
  a_done_with_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last_char) |-> !busy)
    else $error("last character shown while still busy");

  a_fall_on_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> (char_valid && last_char))
    else $error("busy dropped without a last character");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> ((character >= CHAR_ZERO && character <= CHAR_NINE) ||
                    (character >= CHAR_A && character <= CHAR_F) ||
                    character == CHAR_MINUS || character == CHAR_X))
    else $error("illegal output character");

endmodule
